// ===== src/dec_pkg.sv =====
// Shared widths, constants and stage types of the disc elastic collision pipeline.
package dec_pkg;

    // Field widths
    localparam int POS_W  = 16;
    localparam int VEL_W  = 16;
    localparam int MASS_W = 16;

    // Derived internal widths
    localparam int DM_W   = POS_W;            // |d_k|
    localparam int VM_W   = VEL_W;            // |v1_k - v2_k|
    localparam int MS_W   = MASS_W + 1;       // m1 + m2
    localparam int SQ_W   = 2 * DM_W;         // d_k^2
    localparam int D2_W   = SQ_W + 1;         // |d|^2
    localparam int PR_W   = VM_W + DM_W;      // |dv_k| * |d_k|
    localparam int DOT_W  = PR_W + 1;         // |(v1 - v2).d|
    localparam int MD_W   = MASS_W + DM_W;    // m * |d_k|
    localparam int DEN_W  = MS_W + D2_W;      // (m1 + m2) * |d|^2
    localparam int NUM_W  = MD_W + DOT_W + 1; // 2 * m * |d_k| * |dot|
    localparam int Q_W    = VEL_W + 2;        // quotient bits, bounded by 2*sqrt(2)*|dv|
    localparam int R_W    = DEN_W + Q_W + 1;  // remainder and shifted divisor
    localparam int T_W    = Q_W + 3;          // signed update and sum

    localparam int NQ     = 4;                // disc x, disc y, body x, body y

    localparam logic signed [T_W-1:0] VMAX = T_W'((2 ** (VEL_W - 1)) - 1);
    localparam logic signed [T_W-1:0] VMIN = -VMAX - T_W'(1);

    // Data that rides alongside the quotients
    typedef struct packed {
        logic [VEL_W-1:0] v1x;
        logic [VEL_W-1:0] v1y;
        logic [VEL_W-1:0] v2x;
        logic [VEL_W-1:0] v2y;
        logic [1:0]       flip;   // negate the x / y update
        logic             degen;
    } side_t;

    // One division stage
    typedef struct packed {
        logic [DEN_W-1:0]         den;
        logic [NQ-1:0][R_W-1:0]   rem;
        logic [NQ-1:0][Q_W-1:0]   quo;
        side_t                    side;
    } div_t;

endpackage

// ===== src/dec_front.sv =====
// Front stages: differences, products, dot product, numerators and divisor.
module dec_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [dec_pkg::POS_W-1:0]   disc_pos_x,
    input  logic [dec_pkg::POS_W-1:0]   disc_pos_y,
    input  logic [dec_pkg::VEL_W-1:0]   disc_vel_x,
    input  logic [dec_pkg::VEL_W-1:0]   disc_vel_y,
    input  logic [dec_pkg::MASS_W-1:0]  disc_mass,
    input  logic [dec_pkg::POS_W-1:0]   body_pos_x,
    input  logic [dec_pkg::POS_W-1:0]   body_pos_y,
    input  logic [dec_pkg::VEL_W-1:0]   body_vel_x,
    input  logic [dec_pkg::VEL_W-1:0]   body_vel_y,
    input  logic [dec_pkg::MASS_W-1:0]  body_mass,
    output logic                        out_valid,
    output dec_pkg::div_t               out_data
);
    import dec_pkg::*;

    // Stage 1 registers
    logic               s1_vld_reg;
    logic [DM_W-1:0]    s1_dmag_reg [2];
    logic [1:0]         s1_dneg_reg;
    logic [VM_W-1:0]    s1_vmag_reg [2];
    logic [1:0]         s1_vneg_reg;
    logic [MASS_W-1:0]  s1_m1_reg, s1_m2_reg;
    logic [MS_W-1:0]    s1_msum_reg;
    side_t              s1_side_reg;

    // Stage 2 registers
    logic               s2_vld_reg;
    logic [SQ_W-1:0]    s2_sq_reg [2];
    logic [PR_W-1:0]    s2_pr_reg [2];
    logic [MD_W-1:0]    s2_md_reg [NQ];
    logic [1:0]         s2_n_reg;
    logic [1:0]         s2_dneg_reg;
    logic [MS_W-1:0]    s2_msum_reg;
    side_t              s2_side_reg;

    // Stage 3 registers
    logic               s3_vld_reg;
    logic [D2_W-1:0]    s3_d2_reg;
    logic [DOT_W-1:0]   s3_dot_reg;
    logic [MD_W-1:0]    s3_md_reg [NQ];
    logic [MS_W-1:0]    s3_msum_reg;
    side_t              s3_side_reg;

    // Stage 4 registers
    logic               s4_vld_reg;
    div_t               s4_data_reg;

    // Stage 1 logic
    logic signed [POS_W:0] d_next [2];
    logic signed [VEL_W:0] dv_next [2];
    logic [DM_W-1:0]       dmag_next [2];
    logic [VM_W-1:0]       vmag_next [2];

    always_comb
    begin
        d_next[0]  = (POS_W+1)'($signed(body_pos_x)) - (POS_W+1)'($signed(disc_pos_x));
        d_next[1]  = (POS_W+1)'($signed(body_pos_y)) - (POS_W+1)'($signed(disc_pos_y));
        dv_next[0] = (VEL_W+1)'($signed(disc_vel_x)) - (VEL_W+1)'($signed(body_vel_x));
        dv_next[1] = (VEL_W+1)'($signed(disc_vel_y)) - (VEL_W+1)'($signed(body_vel_y));
        for (int k = 0; k < 2; k++)
        begin
            dmag_next[k] = d_next[k][POS_W] ? DM_W'(-d_next[k]) : d_next[k][DM_W-1:0];
            vmag_next[k] = dv_next[k][VEL_W] ? VM_W'(-dv_next[k]) : dv_next[k][VM_W-1:0];
        end
    end

    // Stage 3 logic: dot product magnitude and sign
    logic [D2_W-1:0]  d2_next;
    logic [DOT_W-1:0] dot_next;
    logic             dneg_dot;

    always_comb
    begin
        d2_next = D2_W'(s2_sq_reg[0]) + D2_W'(s2_sq_reg[1]);
        if (s2_n_reg[0] == s2_n_reg[1])
        begin
            dot_next = DOT_W'(s2_pr_reg[0]) + DOT_W'(s2_pr_reg[1]);
            dneg_dot = s2_n_reg[0];
        end
        else if (s2_pr_reg[0] >= s2_pr_reg[1])
        begin
            dot_next = DOT_W'(s2_pr_reg[0] - s2_pr_reg[1]);
            dneg_dot = s2_n_reg[0];
        end
        else
        begin
            dot_next = DOT_W'(s2_pr_reg[1] - s2_pr_reg[0]);
            dneg_dot = s2_n_reg[1];
        end
    end

    // Stage 4 logic: divisor and doubled numerators
    logic [DEN_W-1:0]   den_next;
    logic [NUM_W-2:0]   prod_next [NQ];

    always_comb
    begin
        den_next = s3_msum_reg * s3_d2_reg;
        for (int j = 0; j < NQ; j++)
            prod_next[j] = s3_md_reg[j] * s3_dot_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // Payload, advance on enable
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                s1_dmag_reg[k] <= dmag_next[k];
                s1_vmag_reg[k] <= vmag_next[k];
            end
            s1_dneg_reg      <= {d_next[1][POS_W], d_next[0][POS_W]};
            s1_vneg_reg      <= {dv_next[1][VEL_W], dv_next[0][VEL_W]};
            s1_m1_reg        <= disc_mass;
            s1_m2_reg        <= body_mass;
            s1_msum_reg      <= MS_W'(disc_mass) + MS_W'(body_mass);
            s1_side_reg.v1x  <= disc_vel_x;
            s1_side_reg.v1y  <= disc_vel_y;
            s1_side_reg.v2x  <= body_vel_x;
            s1_side_reg.v2y  <= body_vel_y;
            s1_side_reg.flip <= 2'b00;
            s1_side_reg.degen <= 1'b0;

            for (int k = 0; k < 2; k++)
            begin
                s2_sq_reg[k] <= s1_dmag_reg[k] * s1_dmag_reg[k];
                s2_pr_reg[k] <= s1_vmag_reg[k] * s1_dmag_reg[k];
                s2_md_reg[k]     <= s1_m2_reg * s1_dmag_reg[k];
                s2_md_reg[k + 2] <= s1_m1_reg * s1_dmag_reg[k];
            end
            s2_n_reg    <= s1_vneg_reg ^ s1_dneg_reg;
            s2_dneg_reg <= s1_dneg_reg;
            s2_msum_reg <= s1_msum_reg;
            s2_side_reg <= s1_side_reg;

            s3_d2_reg   <= d2_next;
            s3_dot_reg  <= dot_next;
            for (int j = 0; j < NQ; j++)
                s3_md_reg[j] <= s2_md_reg[j];
            s3_msum_reg <= s2_msum_reg;
            s3_side_reg.v1x   <= s2_side_reg.v1x;
            s3_side_reg.v1y   <= s2_side_reg.v1y;
            s3_side_reg.v2x   <= s2_side_reg.v2x;
            s3_side_reg.v2y   <= s2_side_reg.v2y;
            s3_side_reg.flip  <= s2_dneg_reg ^ {2{dneg_dot}};
            s3_side_reg.degen <= (d2_next == '0) || (s2_msum_reg == '0);

            s4_data_reg.den <= den_next;
            for (int j = 0; j < NQ; j++)
            begin
                s4_data_reg.rem[j] <= R_W'({prod_next[j], 1'b0});
                s4_data_reg.quo[j] <= '0;
            end
            s4_data_reg.side <= s3_side_reg;
        end
    end

    assign out_valid = s4_vld_reg;
    assign out_data  = s4_data_reg;

endmodule

// ===== src/dec_div.sv =====
// Restoring divider pipeline: one quotient bit per stage for all four updates.
module dec_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  dec_pkg::div_t   in_data,
    output logic            out_valid,
    output dec_pkg::div_t   out_data
);
    import dec_pkg::*;

    logic [Q_W-1:0] vld_reg;
    div_t           stage_reg [Q_W];

    genvar s;
    generate
        for (s = 0; s < Q_W; s++)
        begin : g_stage
            localparam int BIT = Q_W - 1 - s;
            div_t           cur;
            div_t           stage_next;
            logic [R_W-1:0] shifted;

            // Pick the stage input
            if (s == 0)
            begin : g_first
                assign cur = in_data;
            end
            else
            begin : g_rest
                assign cur = stage_reg[s-1];
            end

            // Trial subtract of the divisor shifted to this bit
            always_comb
            begin
                stage_next = cur;
                shifted    = R_W'(cur.den) << BIT;
                for (int j = 0; j < NQ; j++)
                begin
                    if (cur.rem[j] >= shifted)
                    begin
                        stage_next.rem[j]      = cur.rem[j] - shifted;
                        stage_next.quo[j][BIT] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s] <= 1'b0;
                else if (en)
                    vld_reg[s] <= (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s - 1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    stage_reg[s] <= stage_next;
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign out_data  = stage_reg[Q_W-1];

endmodule

// ===== src/dec_back.sv =====
// Back stages: round quotients, apply signs, update velocities and saturate.
module dec_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  dec_pkg::div_t             in_data,
    output logic                      out_valid,
    output logic [dec_pkg::VEL_W-1:0] disc_new_vel_x,
    output logic [dec_pkg::VEL_W-1:0] disc_new_vel_y,
    output logic [dec_pkg::VEL_W-1:0] body_new_vel_x,
    output logic [dec_pkg::VEL_W-1:0] body_new_vel_y,
    output logic                      degenerate,
    output logic                      saturated
);
    import dec_pkg::*;

    logic                   b1_vld_reg;
    logic signed [T_W-1:0]  b1_t_reg [NQ];
    side_t                  b1_side_reg;

    logic                   b2_vld_reg;
    logic [VEL_W-1:0]       b2_vel_reg [NQ];
    logic                   b2_degen_reg;
    logic                   b2_sat_reg;

    // Round to nearest and apply the sign
    logic signed [T_W-1:0]  t_next [NQ];
    logic [R_W-1:0]         rem2;
    logic [Q_W:0]           qr;

    always_comb
    begin
        rem2 = '0;
        qr   = '0;
        for (int j = 0; j < NQ; j++)
        begin
            rem2 = {in_data.rem[j][R_W-2:0], 1'b0};
            qr   = {1'b0, in_data.quo[j]} + (Q_W+1)'(rem2 >= R_W'(in_data.den));
            t_next[j] = in_data.side.flip[j % 2] ? -T_W'(qr) : T_W'(qr);
        end
    end

    // Update and clamp
    logic signed [T_W-1:0] base [NQ];
    logic signed [T_W-1:0] sum [NQ];
    logic [VEL_W-1:0]      vel_next [NQ];
    logic                  sat_next;

    always_comb
    begin
        base[0] = T_W'($signed(b1_side_reg.v1x));
        base[1] = T_W'($signed(b1_side_reg.v1y));
        base[2] = T_W'($signed(b1_side_reg.v2x));
        base[3] = T_W'($signed(b1_side_reg.v2y));
        sat_next = 1'b0;
        for (int j = 0; j < NQ; j++)
        begin
            sum[j] = (j < 2) ? base[j] - b1_t_reg[j] : base[j] + b1_t_reg[j];
            if (b1_side_reg.degen)
                vel_next[j] = base[j][VEL_W-1:0];
            else if (sum[j] > VMAX)
            begin
                vel_next[j] = VMAX[VEL_W-1:0];
                sat_next    = 1'b1;
            end
            else if (sum[j] < VMIN)
            begin
                vel_next[j] = VMIN[VEL_W-1:0];
                sat_next    = 1'b1;
            end
            else
                vel_next[j] = sum[j][VEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_vld_reg <= in_valid;
            b2_vld_reg <= b1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NQ; j++)
            begin
                b1_t_reg[j]   <= t_next[j];
                b2_vel_reg[j] <= vel_next[j];
            end
            b1_side_reg  <= in_data.side;
            b2_degen_reg <= b1_side_reg.degen;
            b2_sat_reg   <= sat_next;
        end
    end

    assign out_valid      = b2_vld_reg;
    assign disc_new_vel_x = b2_vel_reg[0];
    assign disc_new_vel_y = b2_vel_reg[1];
    assign body_new_vel_x = b2_vel_reg[2];
    assign body_new_vel_y = b2_vel_reg[3];
    assign degenerate     = b2_degen_reg;
    assign saturated      = b2_sat_reg;

endmodule

// ===== src/disc_elastic_collision.sv =====
// Top level of the pipelined two-disc elastic collision response.
//
// Channel   Dir  Width  Contents
// s_*       in   160    one pair of bodies: positions, velocities, masses
// m_*       out  64+2   new velocities of both bodies, flags in tuser
//
// One item enters per cycle unless the output stalls. Items pass the front
// stages, the restoring divider (one quotient bit per stage) and back end.
// Reset clears only the valid bits; payload registers are left as they are.
// A stall at the output freezes the whole pipeline; s_tready falls only
// while a result waits and m_tready is low.
module disc_elastic_collision (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // disc_pos_x, disc_pos_y, disc_vel_x, disc_vel_y, disc_mass,
    // body_pos_x, body_pos_y, body_vel_x, body_vel_y, body_mass
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // disc_new_vel_x, disc_new_vel_y, body_new_vel_x, body_new_vel_y
    output logic [63:0]  m_tdata,
    // degenerate, saturated
    output logic [1:0]   m_tuser
);
    import dec_pkg::*;

    logic  en;
    logic  f_valid, d_valid;
    div_t  f_data, d_data;
    logic [VEL_W-1:0] dvx, dvy, bvx, bvy;
    logic  degen, sat;

    // Advance everything unless a result is held at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    dec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .disc_pos_x (s_tdata[15:0]),
        .disc_pos_y (s_tdata[31:16]),
        .disc_vel_x (s_tdata[47:32]),
        .disc_vel_y (s_tdata[63:48]),
        .disc_mass  (s_tdata[79:64]),
        .body_pos_x (s_tdata[95:80]),
        .body_pos_y (s_tdata[111:96]),
        .body_vel_x (s_tdata[127:112]),
        .body_vel_y (s_tdata[143:128]),
        .body_mass  (s_tdata[159:144]),
        .out_valid  (f_valid),
        .out_data   (f_data)
    );

    dec_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (d_valid),
        .out_data  (d_data)
    );

    dec_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (d_valid),
        .in_data        (d_data),
        .out_valid      (m_tvalid),
        .disc_new_vel_x (dvx),
        .disc_new_vel_y (dvy),
        .body_new_vel_x (bvx),
        .body_new_vel_y (bvy),
        .degenerate     (degen),
        .saturated      (sat)
    );

    assign m_tdata = {bvy, bvx, dvy, dvx};
    assign m_tuser = {sat, degen};

    // Input is taken exactly when the output side can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // A degenerate pair passes velocities through and never clips
    a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
        else $error("degenerate item flagged as saturated");

    // A clipped item has at least one velocity at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |->
        (dvx == VMAX[VEL_W-1:0] || dvx == VMIN[VEL_W-1:0] ||
         dvy == VMAX[VEL_W-1:0] || dvy == VMIN[VEL_W-1:0] ||
         bvx == VMAX[VEL_W-1:0] || bvx == VMIN[VEL_W-1:0] ||
         bvy == VMAX[VEL_W-1:0] || bvy == VMIN[VEL_W-1:0]))
        else $error("saturated flag without a clipped velocity");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the disc elastic collision pipeline.
`timescale 1ns / 100ps

module tb;
    import dec_pkg::*;

    typedef struct packed {
        logic [63:0] vel;   // disc x, disc y, body x, body y
        logic [1:0]  flags; // degenerate, saturated
    } impact_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    impact_t pending_impacts[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    localparam int QUIET_LIMIT = 3000;

    disc_elastic_collision dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp one velocity to the signed 16-bit range
    function automatic logic [15:0] clamp_vel(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd32767)
        begin
            sat = 1'b1;
            return 16'h7fff;
        end
        if (v < -128'sd32768)
        begin
            sat = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Work out the post-impact velocities of one pair
    function automatic impact_t collide(input logic [159:0] pair);
        longint            dx, dy, dvx, dvy, d2, dot, dk;
        longint            vel[4];
        longint unsigned   m1, m2, msum;
        logic [127:0]      den, num, q, r;
        logic signed [127:0] t;
        logic              sat;
        logic              neg;
        impact_t           res;
        dx  = longint'($signed(pair[95:80]))  - longint'($signed(pair[15:0]));
        dy  = longint'($signed(pair[111:96])) - longint'($signed(pair[31:16]));
        vel[0] = longint'($signed(pair[47:32]));
        vel[1] = longint'($signed(pair[63:48]));
        vel[2] = longint'($signed(pair[127:112]));
        vel[3] = longint'($signed(pair[143:128]));
        m1 = 64'(pair[79:64]);
        m2 = 64'(pair[159:144]);
        msum = m1 + m2;
        d2 = dx * dx + dy * dy;
        sat = 1'b0;
        if (d2 == 0 || msum == 0)
        begin
            res.vel = {pair[143:128], pair[127:112], pair[63:48], pair[47:32]};
            res.flags = 2'b01;
            return res;
        end
        dvx = vel[0] - vel[2];
        dvy = vel[1] - vel[3];
        dot = dvx * dx + dvy * dy;
        den = 128'(msum) * 128'(d2);
        for (int k = 0; k < 4; k++)
        begin
            dk  = (k % 2 == 0) ? dx : dy;
            neg = (dot < 0) != (dk < 0);
            num = 128'(2) * 128'(dk < 0 ? -dk : dk) * 128'(dot < 0 ? -dot : dot)
                  * 128'(k < 2 ? m2 : m1);
            q = num / den;
            r = num % den;
            // round half away from zero
            if ((r << 1) >= den)
                q = q + 128'(1);
            t = neg ? -$signed(q) : $signed(q);
            if (k < 2)
                res.vel[16*k +: 16] = clamp_vel(128'(vel[k]) - t, sat);
            else
                res.vel[16*k +: 16] = clamp_vel(128'(vel[k]) + t, sat);
        end
        res.flags = {sat, 1'b0};
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Offer one pair, wait for it to be taken, then log its expected impact
    task automatic send_pair(input logic [159:0] pair);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pair;
        do
            @(posedge clk);
        while (!s_tready);
        pending_impacts.push_back(collide(pair));
    endtask

    function automatic logic [159:0] pack_pair(
        input logic [15:0] dpx, dpy, dvx, dvy, dm, bpx, bpy, bvx, bvy, bm);
        return {bm, bvy, bvx, bpy, bpx, dm, dvy, dvx, dpy, dpx};
    endfunction

    // Drive tready, with a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_impacts.size() == 0)
            begin
                report_mismatch("unexpected item", m_tdata, 64'h0);
            end
            else
            begin
                impact_t want;
                want = pending_impacts.pop_front();
                for (int k = 0; k < 4; k++)
                    if (m_tdata[16*k +: 16] !== want.vel[16*k +: 16])
                        report_mismatch($sformatf("velocity %0d", k),
                                        64'(m_tdata[16*k +: 16]),
                                        64'(want.vel[16*k +: 16]));
                if (m_tuser[0] !== want.flags[0])
                    report_mismatch("degenerate", 64'(m_tuser[0]), 64'(want.flags[0]));
                if (m_tuser[1] !== want.flags[1])
                    report_mismatch("saturated", 64'(m_tuser[1]), 64'(want.flags[1]));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("disc_elastic_collision verification failed");
                $finish;
            end
        end
    end

    task automatic test_directed();
        // extremes of every field
        send_pair({10{16'h7fff}});
        send_pair({10{16'h8000}});
        send_pair({10{16'hffff}});
        // coincident centres
        send_pair(pack_pair(16'h0100, 16'h0200, 16'h0300, 16'hfd00, 16'h0100,
                            16'h0100, 16'h0200, 16'h1000, 16'h0010, 16'h0200));
        // zero mass sum
        send_pair(pack_pair(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
                            16'h0010, 16'h0000, 16'hff00, 16'h0000, 16'h0000));
        // one zero mass
        send_pair(pack_pair(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
                            16'h0010, 16'h0000, 16'hff00, 16'h0000, 16'h0100));
        // head-on, equal masses: velocities swap
        send_pair(pack_pair(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0100,
                            16'h0010, 16'h0000, 16'hff00, 16'h0000, 16'h0100));
        // diagonal contact
        send_pair(pack_pair(16'h0000, 16'h0000, 16'h0100, 16'h0080, 16'h0100,
                            16'h0010, 16'h0010, 16'h0000, 16'h0000, 16'h0300));
        // saturation both ways
        send_pair(pack_pair(16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h0001,
                            16'h0010, 16'h0010, 16'h8000, 16'h8000, 16'hffff));
        send_pair(pack_pair(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'hffff,
                            16'h0010, 16'h0010, 16'h7fff, 16'h7fff, 16'h0001));
        // widest separation
        send_pair(pack_pair(16'h8000, 16'h8000, 16'h1234, 16'hedcb, 16'h0101,
                            16'h7fff, 16'h7fff, 16'h8765, 16'h0abc, 16'h0202));
        // unit separation, one axis only
        send_pair(pack_pair(16'h0005, 16'h0005, 16'h0001, 16'hffff, 16'h0001,
                            16'h0005, 16'h0006, 16'h0000, 16'h0001, 16'h0001));
        // separating bodies
        send_pair(pack_pair(16'h0000, 16'h0000, 16'hff00, 16'h0000, 16'h0200,
                            16'h0020, 16'h0000, 16'h0100, 16'h0000, 16'h0100));
    endtask

    function automatic logic [159:0] random_pair();
        logic [159:0] pair;
        int           kind;
        pair = {$urandom, $urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            // near neighbours with moderate speeds
            pair[95:80]   = pair[15:0]  + 16'($signed($urandom_range(64)) - 32);
            pair[111:96]  = pair[31:16] + 16'($signed($urandom_range(64)) - 32);
            pair[47:32]   = 16'($signed($urandom_range(2048)) - 1024);
            pair[127:112] = 16'($signed($urandom_range(2048)) - 1024);
        end
        else if (kind < 45)
        begin
            pair[111:80] = pair[31:0];
        end
        else if (kind < 50)
        begin
            pair[79:64]   = 16'h0000;
            pair[159:144] = ($urandom_range(1) == 0) ? 16'h0000 : pair[159:144];
        end
        return pair;
    endfunction

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair());
    endtask

    // Hold the output off while items keep coming, to fill the pipeline
    task automatic test_backpressure();
        hold_left = 200;
        for (int i = 0; i < 60; i++)
            send_pair(random_pair());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle_pct = 38;
        recv_idle_pct = 88;
        test_random(330);
        send_idle_pct = 88;
        recv_idle_pct = 38;
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(320);
        s_tvalid <= 1'b0;

        while (pending_impacts.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("disc_elastic_collision verification clean");
        else
            $display("disc_elastic_collision verification failed");
        $finish;
    end
endmodule
